@@ rtl/core/prmq_pkg.sv @@
package prmq_pkg;

   localparam int MAX_ELEMENTS_DEF = 1024;
   localparam int FIELD_W = 11;
   localparam int VALUE_W = 32;
   localparam int COUNT_RESET = 1024;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_BUILD = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   typedef struct packed {
      logic [1:0]         command;
      logic [FIELD_W-1:0] index;
      logic [VALUE_W-1:0] value_a;
      logic [VALUE_W-1:0] value_b;
      logic [FIELD_W-1:0] range_low;
      logic [FIELD_W-1:0] range_high;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] max_a;
      logic [VALUE_W-1:0] max_b;
      logic               range_error;
   } rsp_type;

   typedef struct packed {
      logic [VALUE_W-1:0] a;
      logic [VALUE_W-1:0] b;
   } pair_type;

endpackage

@@ rtl/core/prmq_ram.sv @@
module prmq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/prmq_max2.sv @@
module prmq_max2 import prmq_pkg::*; (
   input  pair_type x,
   input  pair_type y,
   output pair_type m
);

   assign m.a = (x.a > y.a) ? x.a : y.a;
   assign m.b = (x.b > y.b) ? x.b : y.b;

endmodule

@@ rtl/core/pair_range_max_query.sv @@
// A load writes the element store on acceptance; a build copies the leaves and then, from
// node MAX_ELEMENTS-1 down to the root, stores the maximum of each node's children. A query walks
// the levels, reading at most one node in each S_QRY_L or S_QRY_R state; an error query skips them.
// A finished query waits while an earlier result item is stalled, and so does the input.
// After reset a clearing pass (S_CLEAR) zeroes every entry of the element store, and no
// item is taken meanwhile; configuration writes are taken at any time.
module pair_range_max_query import prmq_pkg::*; #(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic [FIELD_W-1:0] csr_wr_data
);

   localparam int AW = $clog2(2 * MAX_ELEMENTS);
   localparam int NW = AW + 1;
   localparam int EW = $clog2(MAX_ELEMENTS);
   localparam int KW = (NW > FIELD_W) ? NW : FIELD_W;

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_LEAF_RD = 4'd2;
   localparam logic [3:0] S_LEAF_WR = 4'd3;
   localparam logic [3:0] S_NODE_RL = 4'd4;
   localparam logic [3:0] S_NODE_RR = 4'd5;
   localparam logic [3:0] S_NODE_WR = 4'd6;
   localparam logic [3:0] S_QRY_L   = 4'd7;
   localparam logic [3:0] S_QRY_R   = 4'd8;

   logic [3:0]         state_ff, state_in;
   logic [EW-1:0]      clr_ff, clr_in;
   logic [EW-1:0]      leaf_ff, leaf_in;
   logic [AW-1:0]      node_ff, node_in;
   logic [NW-1:0]      l_ff, l_in;
   logic [NW-1:0]      r_ff, r_in;
   pair_type           left_ff, left_in;
   pair_type           acc_ff, acc_in;
   logic               pend_ff, pend_in;
   logic               err_ff, err_in;
   logic               built_ff, built_in;
   logic [FIELD_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic          elem_we;
   logic [EW-1:0] elem_waddr;
   pair_type      elem_wdata;
   logic [EW-1:0] elem_raddr;
   pair_type      elem_rdata;
   logic          tree_we;
   logic [AW-1:0] tree_waddr;
   pair_type      tree_wdata;
   logic [AW-1:0] tree_raddr;
   pair_type      tree_rdata;
   pair_type      max_x;
   pair_type      max_out;
   logic [KW-1:0] n;
   logic          accept;
   logic          idx_ok;
   logic          in_query;

   prmq_ram #(.WIDTH($bits(pair_type)), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_we),
      .wr_addr (elem_waddr),
      .wr_data (elem_wdata),
      .rd_addr (elem_raddr),
      .rd_data (elem_rdata)
   );

   prmq_ram #(.WIDTH($bits(pair_type)), .DEPTH(2 * MAX_ELEMENTS)) u_tree_ram (
      .clock   (clock),
      .wr_en   (tree_we),
      .wr_addr (tree_waddr),
      .wr_data (tree_wdata),
      .rd_addr (tree_raddr),
      .rd_data (tree_rdata)
   );

   prmq_max2 u_max (
      .x (max_x),
      .y (tree_rdata),
      .m (max_out)
   );

   assign in_query  = (state_ff == S_QRY_L) || (state_ff == S_QRY_R);
   assign max_x     = in_query ? acc_ff : left_ff;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign idx_ok    = (KW'(req_data.index) != KW'(0)) &&
                      (KW'(req_data.index) <= KW'(MAX_ELEMENTS));

   always_comb begin
      if (count_ff == '0) begin
         n = KW'(1);
      end else if (KW'(count_ff) > KW'(MAX_ELEMENTS)) begin
         n = KW'(MAX_ELEMENTS);
      end else begin
         n = KW'(count_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      leaf_in      = leaf_ff;
      node_in      = node_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      left_in      = left_ff;
      acc_in       = pend_ff ? max_out : acc_ff;
      pend_in      = 1'b0;
      err_in       = err_ff;
      built_in     = built_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      elem_we      = 1'b0;
      elem_waddr   = clr_ff;
      elem_wdata   = '0;
      elem_raddr   = leaf_ff;
      tree_we      = 1'b0;
      tree_waddr   = node_ff;
      tree_wdata   = max_out;
      tree_raddr   = AW'(l_ff);

      case (state_ff)
         S_CLEAR: begin
            elem_we = 1'b1;
            if (clr_ff == EW'(MAX_ELEMENTS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + EW'(1);
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req_data.command)
                  CMD_LOAD: begin
                     if (idx_ok) begin
                        elem_we      = 1'b1;
                        elem_waddr   = EW'(KW'(req_data.index) - KW'(1));
                        elem_wdata.a = req_data.value_a;
                        elem_wdata.b = req_data.value_b;
                        built_in     = 1'b0;
                     end
                  end
                  CMD_BUILD: begin
                     leaf_in  = '0;
                     state_in = S_LEAF_RD;
                  end
                  CMD_QUERY: begin
                     l_in = NW'(KW'(req_data.range_low) + KW'(MAX_ELEMENTS) - KW'(1));
                     r_in = NW'(KW'(req_data.range_high) + KW'(MAX_ELEMENTS));
                     err_in = !built_ff || (req_data.range_low == '0) ||
                              (KW'(req_data.range_high) > n) ||
                              (req_data.range_low > req_data.range_high);
                     acc_in   = '0;
                     state_in = S_QRY_L;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LEAF_RD: begin
            state_in = S_LEAF_WR;
         end
         S_LEAF_WR: begin
            tree_we    = 1'b1;
            tree_waddr = AW'(MAX_ELEMENTS) + AW'(leaf_ff);
            tree_wdata = (KW'(leaf_ff) < n) ? elem_rdata : '0;
            if (leaf_ff == EW'(MAX_ELEMENTS - 1)) begin
               node_in  = AW'(MAX_ELEMENTS - 1);
               state_in = S_NODE_RL;
            end else begin
               leaf_in  = leaf_ff + EW'(1);
               state_in = S_LEAF_RD;
            end
         end
         S_NODE_RL: begin
            tree_raddr = {node_ff[AW-2:0], 1'b0};
            state_in   = S_NODE_RR;
         end
         S_NODE_RR: begin
            tree_raddr = {node_ff[AW-2:0], 1'b1};
            left_in    = tree_rdata;
            state_in   = S_NODE_WR;
         end
         S_NODE_WR: begin
            tree_we = 1'b1;
            if (node_ff == AW'(1)) begin
               built_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               node_in  = node_ff - AW'(1);
               state_in = S_NODE_RL;
            end
         end
         S_QRY_L: begin
            if (err_ff || !(l_ff < r_ff)) begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_in = 1'b1;
                  if (err_ff) begin
                     rsp_data_in.max_a       = '0;
                     rsp_data_in.max_b       = '0;
                     rsp_data_in.range_error = 1'b1;
                  end else begin
                     rsp_data_in.max_a       = acc_in.a;
                     rsp_data_in.max_b       = acc_in.b;
                     rsp_data_in.range_error = 1'b0;
                  end
                  state_in = S_IDLE;
               end
            end else begin
               if (l_ff[0]) begin
                  tree_raddr = AW'(l_ff);
                  pend_in    = 1'b1;
                  l_in       = l_ff + NW'(1);
               end
               state_in = S_QRY_R;
            end
         end
         S_QRY_R: begin
            l_in = l_ff >> 1;
            r_in = r_ff >> 1;
            if (r_ff[0]) begin
               tree_raddr = AW'(r_ff - NW'(1));
               pend_in    = 1'b1;
            end
            state_in = S_QRY_L;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      count_in = count_ff;
      if (csr_wr_en) begin
         count_in = csr_wr_data;
         built_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         built_ff     <= 1'b0;
         count_ff     <= FIELD_W'(COUNT_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         built_ff     <= built_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      leaf_ff     <= leaf_in;
      node_ff     <= node_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      left_ff     <= left_in;
      acc_ff      <= acc_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_QRY_L))
      else $error("A result item appeared outside the end of a query.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.range_error) |->
         (rsp_data_ff.max_a == '0) && (rsp_data_ff.max_b == '0))
      else $error("An error result item carries nonzero maxima.");

   assert property (@(posedge clock) disable iff (reset)
      $rose(built_ff) |-> $past(state_ff == S_NODE_WR))
      else $error("The built flag was set before the root node was written.");

endmodule
